// ===== hw/rtl/dsd_pkg.sv =====
// Shared types, codes and default sizes for the deck shuffle and draw block.
`timescale 1ns / 1ps

package dsd_pkg;

	localparam int DEPTH_DEF    = 64;
	localparam int CARD_W_DEF   = 8;
	localparam int SAMPLE_W_DEF = 15;

	// Width of the deck size register, the deal position and the shuffle position.
	localparam int SIZE_W = 7;
	localparam logic [SIZE_W-1:0] DECK_SIZE_RST = SIZE_W'(40);

	typedef enum logic [2:0] {
		OP_WRITE   = 3'd0,
		OP_SHUFFLE = 3'd1,
		OP_SAMPLE  = 3'd2,
		OP_DRAW    = 3'd3,
		OP_RESTART = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ERR  = 2'd1,
		ST_REJ  = 2'd2,
		ST_DONE = 2'd3
	} st_t;

	typedef struct packed {
		logic load_in;
		logic write_card;
		logic set_shuffle;
		logic deal_inc;
		logic deal_clr;
		logic rd_deal;
		logic cap_card;
		logic div_start;
		logic div_step;
		logic rd_pos;
		logic rd_j;
		logic cap_a;
		logic wr_pos;
		logic wr_j;
		logic out_load;
		st_t  res;
	} dsd_cmd_t;

	typedef struct packed {
		op_t  op;
		logic busy;
		logic n_zero;
		logic n_one;
		logic deal_ok;
		logic div_last;
		logic reject;
		logic pos_last;
		logic out_free;
	} dsd_stat_t;

endpackage

// ===== hw/rtl/dsd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module dsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/dsd_ctrl.sv =====
// Controller state machine that sequences each operation of the deck block.
`timescale 1ns / 1ps

module dsd_ctrl import dsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dsd_stat_t stat,
	output dsd_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_DRAW_CAP,
		S_DIV,
		S_CHECK,
		S_RD_B,
		S_WR_A,
		S_WR_B,
		S_RESP
	} state_t;

	state_t state_q, state_d;
	st_t    res_q, res_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.res = res_q;
		state_d = state_q;
		res_d   = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				res_d   = ST_ERR;
				state_d = S_RESP;
				if (stat.op == OP_SAMPLE) begin
					if (stat.busy) begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end
				end else if (!stat.busy) begin
					case (stat.op)
						OP_WRITE: begin
							cmd.write_card = 1'b1;
							res_d          = ST_OK;
						end
						OP_SHUFFLE: begin
							if (stat.n_one) begin
								res_d = ST_DONE;
							end else if (!stat.n_zero) begin
								cmd.set_shuffle = 1'b1;
								res_d           = ST_OK;
							end
						end
						OP_DRAW: begin
							if (stat.deal_ok) begin
								cmd.rd_deal = 1'b1;
								state_d     = S_DRAW_CAP;
							end
						end
						OP_RESTART: begin
							cmd.deal_clr = 1'b1;
							res_d        = ST_OK;
						end
						default: begin
							res_d = ST_ERR;
						end
					endcase
				end
			end
			S_DRAW_CAP: begin
				cmd.cap_card = 1'b1;
				cmd.deal_inc = 1'b1;
				res_d        = ST_OK;
				state_d      = S_RESP;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.reject) begin
					res_d   = ST_REJ;
					state_d = S_RESP;
				end else begin
					cmd.rd_pos = 1'b1;
					state_d    = S_RD_B;
				end
			end
			S_RD_B: begin
				cmd.rd_j  = 1'b1;
				cmd.cap_a = 1'b1;
				state_d   = S_WR_A;
			end
			S_WR_A: begin
				cmd.wr_pos = 1'b1;
				state_d    = S_WR_B;
			end
			S_WR_B: begin
				cmd.wr_j = 1'b1;
				res_d    = stat.pos_last ? ST_DONE : ST_OK;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

// ===== hw/rtl/dsd_dp.sv =====
// Datapath: deck registers, sample remainder unit, swap buffer and output word register.
`timescale 1ns / 1ps

module dsd_dp import dsd_pkg::*; #(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int CARD_WIDTH   = CARD_W_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic [SIZE_W-1:0]        cfg_data,
	input  logic [2:0]               op,
	input  logic [$clog2(DEPTH)-1:0] card_index,
	input  logic [CARD_WIDTH-1:0]    card_value,
	input  logic [SAMPLE_WIDTH-1:0]  random_sample,
	input  dsd_cmd_t                 cmd,
	output dsd_stat_t                stat,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic [1:0]               status,
	output logic [CARD_WIDTH-1:0]    card_out,
	output logic [SIZE_W-1:0]        cards_left,
	output logic                     shuffling,
	output logic                     ram_we,
	output logic [$clog2(DEPTH)-1:0] ram_waddr,
	output logic [CARD_WIDTH-1:0]    ram_wdata,
	output logic                     ram_re,
	output logic [$clog2(DEPTH)-1:0] ram_raddr,
	input  logic [CARD_WIDTH-1:0]    ram_rdata
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(SAMPLE_WIDTH);
	localparam int SIZE_TOP = (1 << SIZE_W) - 1;
	localparam logic [SIZE_W-1:0] DEPTH_CAP =
		SIZE_W'((DEPTH > SIZE_TOP) ? SIZE_TOP : DEPTH);
	localparam logic [SAMPLE_WIDTH:0] RANGE = {1'b1, {SAMPLE_WIDTH{1'b0}}};
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_WIDTH - 1);

	logic [SIZE_W-1:0]       deck_size_q;
	logic [SIZE_W-1:0]       deal_q;
	logic [SIZE_W-1:0]       pos_q;
	logic                    busy_q;
	logic [2:0]              op_q;
	logic [AW-1:0]           index_q;
	logic [CARD_WIDTH-1:0]   value_q;
	logic [SAMPLE_WIDTH-1:0] sample_q;
	logic [SAMPLE_WIDTH-1:0] shift_q;
	logic [SIZE_W-1:0]       rem_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CARD_WIDTH-1:0]   card_q;
	logic [CARD_WIDTH-1:0]   tmp_a_q;
	logic                    out_valid_q;
	logic [1:0]              status_q;
	logic [CARD_WIDTH-1:0]   card_out_q;
	logic [SIZE_W-1:0]       cards_left_q;
	logic                    shuffling_q;

	logic [SIZE_W-1:0]       eff_size;
	logic [SIZE_W-1:0]       lim;
	logic [SIZE_W:0]         rem_shift;
	logic [SIZE_W-1:0]       rem_next;
	logic [SAMPLE_WIDTH:0]   top_sum;
	logic [SIZE_W-1:0]       left_now;

	assign eff_size = (deck_size_q > DEPTH_CAP) ? DEPTH_CAP : deck_size_q;
	assign lim      = pos_q + SIZE_W'(1);
	assign left_now = (deal_q < eff_size) ? (eff_size - deal_q) : '0;

	// One restoring division step: bring in the next sample bit, subtract the limit if it fits.
	assign rem_shift = {rem_q, shift_q[SAMPLE_WIDTH-1]};
	assign rem_next  = (rem_shift >= {1'b0, lim}) ? SIZE_W'(rem_shift - {1'b0, lim})
		: SIZE_W'(rem_shift);

	// The sample minus its remainder is a multiple of the limit; it lies in the rejected
	// zone exactly when adding one more limit passes the full sample range.
	assign top_sum = {1'b0, sample_q} - (SAMPLE_WIDTH + 1)'(rem_q)
		+ (SAMPLE_WIDTH + 1)'(lim);

	always_comb begin
		stat          = '0;
		stat.op       = op_t'(op_q);
		stat.busy     = busy_q;
		stat.n_zero   = (eff_size == '0);
		stat.n_one    = (eff_size == SIZE_W'(1));
		stat.deal_ok  = (deal_q < eff_size);
		stat.div_last = (cnt_q == CNT_LAST);
		stat.reject   = (top_sum > RANGE);
		stat.pos_last = (pos_q == SIZE_W'(1));
		stat.out_free = !out_valid_q || !out_stall;
	end

	always_comb begin
		ram_we    = cmd.write_card || cmd.wr_pos || cmd.wr_j;
		ram_waddr = index_q;
		ram_wdata = value_q;
		if (cmd.wr_pos) begin
			ram_waddr = AW'(pos_q);
			ram_wdata = ram_rdata;
		end else if (cmd.wr_j) begin
			ram_waddr = AW'(rem_q);
			ram_wdata = tmp_a_q;
		end
		ram_re    = cmd.rd_deal || cmd.rd_pos || cmd.rd_j;
		ram_raddr = AW'(deal_q);
		if (cmd.rd_pos) begin
			ram_raddr = AW'(pos_q);
		end else if (cmd.rd_j) begin
			ram_raddr = AW'(rem_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deck_size_q <= DECK_SIZE_RST;
			deal_q      <= '0;
			pos_q       <= '0;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				deck_size_q <= cfg_data;
			end
			if (cmd.deal_clr) begin
				deal_q <= '0;
			end else if (cmd.deal_inc) begin
				deal_q <= deal_q + SIZE_W'(1);
			end
			if (cmd.set_shuffle) begin
				pos_q  <= eff_size - SIZE_W'(1);
				busy_q <= 1'b1;
			end else if (cmd.wr_j) begin
				pos_q <= pos_q - SIZE_W'(1);
				if (pos_q == SIZE_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= op;
			index_q  <= card_index;
			value_q  <= card_value;
			sample_q <= random_sample;
			card_q   <= '0;
		end
		if (cmd.div_start) begin
			shift_q <= sample_q;
			rem_q   <= '0;
		end else if (cmd.div_step) begin
			shift_q <= {shift_q[SAMPLE_WIDTH-2:0], 1'b0};
			rem_q   <= rem_next;
		end
		if (cmd.cap_card) begin
			card_q <= ram_rdata;
		end
		if (cmd.cap_a) begin
			tmp_a_q <= ram_rdata;
		end
		if (cmd.out_load) begin
			status_q     <= cmd.res;
			card_out_q   <= card_q;
			cards_left_q <= left_now;
			shuffling_q  <= busy_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign card_out   = card_out_q;
	assign cards_left = cards_left_q;
	assign shuffling  = shuffling_q;

endmodule

// ===== hw/rtl/deck_shuffle_and_draw.sv =====
// Top level of the deck shuffle and draw block.
`timescale 1ns / 1ps

// Card store with an in-place Fisher-Yates shuffle fed by outside random words.
// Every input word gives exactly one result word. The block takes one word at a
// time. Write card, restart deal, start shuffle and every error go from the
// decode state straight to the response state. A draw adds a capture state
// because of the registered read of the card RAM. A random sample first runs
// a restoring remainder unit that handles one sample bit per cycle, then
// checks the rejection zone. A rejected sample then goes to the response
// state. An accepted sample then swaps two cards through the single read
// port and single write port of the card RAM. A new word is accepted while
// the last result still waits in the output register. Card entries hold no
// reset value, and they must be written before a draw or a shuffle reads
// them. The deck size register may be written at any time; it is always
// ready.
module deck_shuffle_and_draw import dsd_pkg::*; #(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int CARD_WIDTH   = CARD_W_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [SIZE_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               op,
	input  logic [$clog2(DEPTH)-1:0] card_index,
	input  logic [CARD_WIDTH-1:0]    card_value,
	input  logic [SAMPLE_WIDTH-1:0]  random_sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic [CARD_WIDTH-1:0]    card_out,
	output logic [SIZE_W-1:0]        cards_left,
	output logic                     shuffling
);

	localparam int AW = $clog2(DEPTH);

	dsd_cmd_t              cmd;
	dsd_stat_t             stat;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [CARD_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [CARD_WIDTH-1:0] ram_rdata;

	assign cfg_ready = 1'b1;

	dsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsd_dp #(
		.DEPTH        (DEPTH),
		.CARD_WIDTH   (CARD_WIDTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.op            (op),
		.card_index    (card_index),
		.card_value    (card_value),
		.random_sample (random_sample),
		.cmd           (cmd),
		.stat          (stat),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.card_out      (card_out),
		.cards_left    (cards_left),
		.shuffling     (shuffling),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

	dsd_ram #(
		.WIDTH (CARD_WIDTH),
		.DEPTH (DEPTH)
	) u_card_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
